### rtl/core/sut_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sut_pkg;

    // operation codes
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_POP    = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    // result status codes
    typedef enum logic [2:0] {
        ST_DONE   = 3'd0,
        ST_DUP    = 3'd1,
        ST_ABSENT = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_FULL   = 3'd4
    } t_status;

    localparam int unsigned ValueW = 32;
    localparam int unsigned CountW = 5;

endpackage

`default_nettype wire

### rtl/core/sorted_unique_value_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted unique value table.
// Holds up to DEPTH distinct signed 32-bit values in ascending order in a
// single-port-write / single-port-read RAM (registered read).
// Command channel: a beat is taken at a rising edge with start high and busy
// low. i_func selects insert (0), delete (1) or pop smallest (2); code 3 is a
// no-op. i_value is the key for insert/delete, ignored for pop.
// Result channel: o_done pulses for exactly one cycle per command; o_status,
// o_popped_value and o_count are valid in that cycle. The receiver cannot
// stall, so a result is never held back; busy drops in the same cycle.
// One command at a time. A linear search reads the entries in turn up to
// the first one that is not below the key, then entries move one slot per
// step (check, read, write) to open or close the gap. Insert, delete and
// pop share the RAM port and this compare/move loop.
// Reset: synchronous, active low; count goes to zero. RAM contents are not
// cleared; only entries below the count are ever read.
module sorted_unique_value_table_top #(
    parameter int DEPTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              i_func,
    input  wire logic signed [31:0]      i_value,
    output logic                         o_done,
    output logic [2:0]                   o_status,
    output logic signed [31:0]           o_popped_value,
    output logic [sut_pkg::CountW-1:0]   o_count
);
    import sut_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_POP_RD,
        S_POP_CAP,
        S_SH_CHK,
        S_SH_RD,
        S_SH_WR,
        S_WR_NEW
    } t_state;

    t_state                    r_state;
    t_func                     r_func;
    logic signed [ValueW-1:0]  r_key;
    logic signed [ValueW-1:0]  r_popped;
    t_status                   r_status;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_idx;
    logic [CW-1:0]             r_slot;
    logic                      r_found;
    logic                      r_dir;     // 0: move up (insert), 1: move down

    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [ValueW-1:0]         w_wdata;
    logic [AW-1:0]             w_raddr;
    logic [ValueW-1:0]         w_rdata;
    logic [CW-1:0]             w_src;
    logic [CW+CountW-1:0]      w_cnt_wide;

    // source slot of the current move
    assign w_src = r_dir ? (r_idx + CW'(1)) : (r_idx - CW'(1));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = w_rdata;
        w_raddr = r_idx[AW-1:0];
        case (r_state)
            S_POP_RD: begin
                w_raddr = '0;
            end
            S_SH_RD: begin
                w_raddr = w_src[AW-1:0];
            end
            S_SH_WR: begin
                w_we = 1'b1;
            end
            S_WR_NEW: begin
                w_we    = 1'b1;
                w_waddr = r_slot[AW-1:0];
                w_wdata = r_key;
            end
            default: begin
            end
        endcase
    end

    sut_ram #(
        .WIDTH (ValueW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func   <= t_func'(i_func);
                        r_key    <= i_value;
                        r_popped <= '0;
                        r_idx    <= '0;
                        case (t_func'(i_func))
                            FN_INSERT, FN_DELETE: r_state <= S_SRCH_RD;
                            FN_POP:               r_state <= S_POP_RD;
                            default: begin
                                r_status <= ST_DONE;
                                o_done   <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SRCH_RD: begin
                    if (r_idx >= r_count) begin
                        r_slot  <= r_idx;
                        r_found <= 1'b0;
                        r_state <= S_DECIDE;
                    end else begin
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if ($signed(w_rdata) < r_key) begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SRCH_RD;
                    end else begin
                        r_slot  <= r_idx;
                        r_found <= ($signed(w_rdata) == r_key);
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_func == FN_INSERT) begin
                        if (r_found) begin
                            r_status <= ST_DUP;
                            o_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else if (r_count == CW'(DEPTH)) begin
                            r_status <= ST_FULL;
                            o_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_idx   <= r_count;
                            r_dir   <= 1'b0;
                            r_state <= S_SH_CHK;
                        end
                    end else if (r_found) begin
                        r_idx   <= r_slot;
                        r_dir   <= 1'b1;
                        r_state <= S_SH_CHK;
                    end else begin
                        r_status <= ST_ABSENT;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_POP_RD: begin
                    if (r_count == '0) begin
                        r_status <= ST_EMPTY;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_POP_CAP;
                    end
                end
                S_POP_CAP: begin
                    r_popped <= w_rdata;
                    r_idx    <= '0;
                    r_dir    <= 1'b1;
                    r_state  <= S_SH_CHK;
                end
                S_SH_CHK: begin
                    if (!r_dir) begin
                        r_state <= (r_idx > r_slot) ? S_SH_RD : S_WR_NEW;
                    end else if ((r_idx + CW'(1)) < r_count) begin
                        r_state <= S_SH_RD;
                    end else begin
                        r_count  <= r_count - CW'(1);
                        r_status <= ST_DONE;
                        o_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_idx   <= w_src;
                    r_state <= S_SH_CHK;
                end
                S_WR_NEW: begin
                    r_count  <= r_count + CW'(1);
                    r_status <= ST_DONE;
                    o_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_status       = r_status;
    assign o_popped_value = r_popped;
    assign w_cnt_wide     = {{CountW{1'b0}}, r_count};
    assign o_count        = w_cnt_wide[CountW-1:0];

    // result strobe never overlaps busy; a no-op answers straight from idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while a command is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status with free entries");

    a_empty_only_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with stored entries");

endmodule

`default_nettype wire

### rtl/core/sut_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sut_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
